// ===== sv/rainbow_color_cycle_defines.svh =====
// assertion macros for the colour cycle block
`ifndef RAINBOW_COLOR_CYCLE_DEFINES_SVH
`define RAINBOW_COLOR_CYCLE_DEFINES_SVH

`ifndef SYNTHESIS
`define RCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define RCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RCC_ASSERT_SAME(lbl, ante, cons, msg)
`define RCC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/rcc_pkg.sv =====
package rcc_pkg;

  localparam int CountW   = 11;
  localparam int FramesW  = 8;
  localparam int ChanW    = 8;
  localparam int DivNumW  = 16;
  localparam int StepW    = 4;
  localparam int SegW     = 3;

  localparam logic [FramesW-1:0] CycleFramesReset = 8'd16;
  localparam logic [ChanW-1:0]   LevelHi          = 8'hE0;
  localparam logic [ChanW-1:0]   LevelLo          = 8'h10;
  // hi minus lo, the full swing of a channel across one segment
  localparam logic [ChanW-1:0]   LevelSwing       = 8'd208;

  typedef struct packed {
    logic load_in;
    logic start_seg;
    logic latch_seg;
    logic start_blend;
    logic load_out;
  } rcc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } rcc_sts_t;

  // wheel entries: red, yellow, green, cyan, blue, purple, red
  function automatic logic [ChanW-1:0] wheel_level(input logic [SegW-1:0] idx,
                                                   input logic [1:0] ch);
    logic hi;
    begin
      hi = 1'b0;
      unique case (ch)
        2'd0: hi = (idx == 3'd0) || (idx == 3'd1) || (idx == 3'd5) || (idx == 3'd6);
        2'd1: hi = (idx == 3'd1) || (idx == 3'd2) || (idx == 3'd3);
        2'd2: hi = (idx == 3'd3) || (idx == 3'd4) || (idx == 3'd5);
        default: hi = 1'b0;
      endcase
      wheel_level = hi ? LevelHi : LevelLo;
    end
  endfunction

endpackage

// ===== sv/rainbow_color_cycle.sv =====
// channel | direction | payload
// in_     | request   | tdata[0] tick
// out_    | result    | tdata[7:0] red, [15:8] green, [23:16] blue
// cfg_    | write     | wr_data cycle_frames
//
// each request runs the shared 16-step serial divider twice (segment split, then blend),
// with the controller handing off through states SEG, DIV1, MUL, DIV2 and OUT in turn
// a new request is taken once the previous result sits in the output register
// a stalled result holds the controller in its final state until taken
// reset clears the frame count to zero and sets cycle_frames to 16
module rainbow_color_cycle
  import rcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,    // [0] tick
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic               cfg_wr_en,
  input  logic [FramesW-1:0] cfg_wr_data
);

  rcc_cmd_t         cmd;
  rcc_sts_t         sts;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  rcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rcc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tick     (in_tdata[0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_red     (red),
    .out_green   (green),
    .out_blue    (blue)
  );

  assign out_tdata = {blue, green, red};

endmodule

// ===== sv/rcc_div.sv =====
module rcc_div
  import rcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DivNumW-1:0] dividend,
  input  logic [FramesW-1:0] divisor,
  output logic               done,
  output logic [DivNumW-1:0] quo,
  output logic [FramesW-1:0] rem
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic [DivNumW-1:0] quo_r, quo_nxt;
  logic [FramesW-1:0] rem_r, rem_nxt;
  logic [FramesW-1:0] div_r, div_nxt;
  logic [FramesW:0]   trial;
  logic               fits;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_r, quo_r[DivNumW-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[DivNumW-2:0], fits};
      rem_nxt  = fits ? FramesW'(trial - {1'b0, div_r}) : trial[FramesW-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== sv/rcc_dp.sv =====
module rcc_dp
  import rcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  rcc_cmd_t           cmd,
  output rcc_sts_t           sts,
  input  logic               in_tick,
  input  logic               cfg_wr_en,
  input  logic [FramesW-1:0] cfg_wr_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [ChanW-1:0]   out_red,
  output logic [ChanW-1:0]   out_green,
  output logic [ChanW-1:0]   out_blue
);

  logic [FramesW-1:0] cycle_frames_r;
  logic [CountW-1:0]  frame_count_r, frame_count_nxt;
  logic [SegW-1:0]    seg_r;
  logic [FramesW-1:0] off_r;
  logic               out_valid_r, out_valid_nxt;
  logic [ChanW-1:0]   red_r, green_r, blue_r;

  logic [FramesW-1:0] period;
  logic [CountW-1:0]  limit;
  logic [CountW-1:0]  count_inc;
  logic [CountW-1:0]  count_eff;
  logic               div_start;
  logic [DivNumW-1:0] div_num;
  logic               div_done;
  logic [DivNumW-1:0] div_quo;
  logic [FramesW-1:0] div_rem;
  logic [ChanW-1:0]   step_dn;
  logic [ChanW-1:0]   mix [3];

  assign period = (cycle_frames_r == '0) ? FramesW'(1) : cycle_frames_r;
  assign limit  = (CountW'(period) << 2) + (CountW'(period) << 1);

  assign count_inc = frame_count_r + 1'b1;
  always_comb begin
    frame_count_nxt = frame_count_r;
    if (cmd.load_in && in_tick) begin
      frame_count_nxt = (count_inc >= limit) ? '0 : count_inc;
    end
  end

  // a count left stale by a smaller period reports as count zero
  assign count_eff = (frame_count_r < limit) ? frame_count_r : '0;

  assign div_start = cmd.start_seg || cmd.start_blend;
  assign div_num   = cmd.start_seg ? DivNumW'(count_eff)
                                   : DivNumW'(off_r) * DivNumW'(LevelSwing);

  rcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (period),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // falling channel needs the ceiling of the swing fraction
  assign step_dn = div_quo[ChanW-1:0] + ChanW'(div_rem != '0);

  always_comb begin
    logic [ChanW-1:0] a;
    logic [ChanW-1:0] b;
    for (int c = 0; c < 3; c++) begin
      a = wheel_level(seg_r, 2'(c));
      b = wheel_level(seg_r + 1'b1, 2'(c));
      if (a == b) begin
        mix[c] = a;
      end else if (b > a) begin
        mix[c] = a + div_quo[ChanW-1:0];
      end else begin
        mix[c] = a - step_dn;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_frames_r <= CycleFramesReset;
      frame_count_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cycle_frames_r <= cfg_wr_data;
      end
      frame_count_r <= frame_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_seg) begin
      seg_r <= div_quo[SegW-1:0];
      off_r <= div_rem;
    end
    if (cmd.load_out) begin
      red_r   <= mix[0];
      green_r <= mix[1];
      blue_r  <= mix[2];
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_red      = red_r;
  assign out_green    = green_r;
  assign out_blue     = blue_r;

endmodule

// ===== sv/rcc_ctrl.sv =====
`include "rainbow_color_cycle_defines.svh"

module rcc_ctrl
  import rcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output rcc_cmd_t cmd,
  input  rcc_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEG  = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SEG;
        end
      end
      S_SEG: begin
        cmd.start_seg = 1'b1;
        state_nxt     = S_DIV1;
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.latch_seg = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.start_blend = 1'b1;
        state_nxt       = S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `RCC_ASSERT_SAME(a_load_out_free, cmd.load_out, sts.out_free, "result loaded over a waiting one")
  `RCC_ASSERT_NEXT(a_start_busy, cmd.start_seg || cmd.start_blend, !sts.div_done, "divider done too early")
  `RCC_ASSERT_NEXT(a_blend_to_out, (state_r == S_DIV2) && sts.div_done, state_r == S_OUT, "blend result lost")

endmodule

// ===== bench/testbench.sv =====
module testbench
  import rcc_pkg::*;
;

  localparam int CycleLimit = 400000;
  // which channels sit high on each wheel entry, bit 0 red, bit 1 green, bit 2 blue
  localparam logic [2:0] WheelHigh [7] = '{3'b001, 3'b011, 3'b010, 3'b110,
                                           3'b100, 3'b101, 3'b001};

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } colour_t;

  class colour_wheel_check;
    logic [FramesW-1:0] frames;
    logic [CountW-1:0]  frame_no;
    colour_t            colours_due[$];
    int                 errors;

    function new();
      frames   = CycleFramesReset;
      frame_no = '0;
      errors   = 0;
    endfunction

    function void set_frames(logic [FramesW-1:0] value);
      frames = value;
    endfunction

    function int pending();
      return colours_due.size();
    endfunction

    function logic [ChanW-1:0] level(int unsigned entry, int ch);
      return WheelHigh[entry][ch] ? LevelHi : LevelLo;
    endfunction

    function logic [ChanW-1:0] mix(int unsigned entry, int ch, int unsigned n,
                                   int unsigned off);
      int unsigned a;
      int unsigned b;
      a = level(entry, ch);
      b = level(entry + 1, ch);
      return ChanW'((a * (n - off) + b * off) / n);
    endfunction

    function void note_request(logic tick);
      int unsigned n;
      int unsigned wrap_at;
      int unsigned pos;
      int unsigned seg;
      int unsigned off;
      colour_t     c;
      n       = (frames == 0) ? 1 : frames;
      wrap_at = 6 * n;
      if (tick) begin
        frame_no = frame_no + 1'b1;
        if (frame_no >= wrap_at) frame_no = '0;
      end
      // a count left over from a longer period reports as the start of the wheel
      pos = (frame_no < wrap_at) ? frame_no : 0;
      seg = pos / n;
      off = pos % n;
      if (seg > 5) seg = 0;
      c.red   = mix(seg, 0, n, off);
      c.green = mix(seg, 1, n, off);
      c.blue  = mix(seg, 2, n, off);
      colours_due.push_back(c);
    endfunction

    function void check_colour(colour_t got);
      colour_t want;
      if (colours_due.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = colours_due.pop_front();
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;    // [0] tick
  logic               out_tvalid;
  logic               out_tready;
  logic [23:0]        out_tdata;   // [7:0] red, [15:8] green, [23:16] blue
  logic               cfg_wr_en;
  logic [FramesW-1:0] cfg_wr_data;

  colour_wheel_check colours = new();
  int                idle_pct;
  int                cycles;

  rainbow_color_cycle i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  initial begin : receiver
    int  taken;
    int  idle_left;
    int  hold_left;
    bit  held;
    logic ready;
    taken     = 0;
    idle_left = 0;
    hold_left = 0;
    held      = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        colours.check_colour(colour_t'(out_tdata));
        taken++;
      end
      if (taken == 600 && !held) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        ready = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        idle_left = $urandom_range(1, 7) - 1;
        ready     = 1'b0;
      end else begin
        ready = 1'b1;
      end
      out_tready <= ready;
    end
  end

  task automatic offer(input logic [7:0] word);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    colours.note_request(word[0]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (colours.pending() != 0) @(posedge clk);
  endtask

  task automatic write_frames(input logic [FramesW-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    colours.set_frames(value);
  endtask

  initial begin : stimulus
    int unsigned phase_frames [12];
    int unsigned phase_len [12];
    logic [7:0]  word;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    idle_pct = 25;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset period: report twice, step across the first segment edge,
    // then check that the upper data bits are ignored
    offer(8'h00);
    offer(8'h00);
    for (int i = 0; i < 17; i++) offer(8'h01);
    offer(8'h00);
    offer(8'hFF);
    offer(8'hFE);

    phase_frames = '{0, 1, 255, 4, 2, 40, 3, 0, 0, 7, 0, 16};
    phase_len    = '{50, 60, 320, 80, 60, 280, 60, 100, 100, 100, 120, 200};
    phase_frames[7]  = $urandom_range(0, 255);
    phase_frames[8]  = $urandom_range(1, 30);
    phase_frames[10] = $urandom_range(0, 255);

    for (int p = 0; p < 12; p++) begin
      write_frames(FramesW'(phase_frames[p]));
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 20;
        default: idle_pct = 50;
      endcase
      if (p == 11) idle_pct = 0;
      for (int i = 0; i < phase_len[p]; i++) begin
        word[7:1] = 7'($urandom);
        // open each phase with a bare report, catching a count left stale
        word[0]   = (i == 0) ? 1'b0 : ($urandom_range(99) < 80);
        offer(word);
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (colours.errors == 0 && colours.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
